FILE: sv/lgtp_pkg.sv
// ----------------------------------------------------------------------------
// lgtp_pkg
// Shared types and constants for the gait trajectory point pipeline.
// ----------------------------------------------------------------------------
package lgtp_pkg;

  localparam int unsigned QUO_W = 16;
  localparam int unsigned ANG_W = 16;

  localparam longint HALFPI_Q30 = 64'sd1686629713;
  localparam longint Q30_ONE    = 64'sd1073741824;
  localparam longint Q30_HALF   = 64'sd536870912;

  typedef logic [ANG_W-1:0] bangle_t;
  typedef logic signed [15:0] q15_t;

endpackage

FILE: sv/lgtp_div.sv
// ----------------------------------------------------------------------------
// lgtp_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module lgtp_div #(
  parameter int unsigned DEN_W = 10
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [DEN_W-1:0]                   den_i,
  input  logic [DEN_W+lgtp_pkg::QUO_W-1:0]   num_i,
  output logic [lgtp_pkg::QUO_W-1:0]         quo_o
);
  import lgtp_pkg::*;

  // quotient is known to fit QUO_W bits, so the upper bits seed the remainder
  logic [DEN_W-1:0] rem_q [QUO_W-1];
  logic [QUO_W-1:0] wrk_q [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    logic [DEN_W-1:0] rem_src;
    logic [QUO_W-1:0] wrk_src;
    logic [DEN_W:0]   trial;
    logic             ge;

    if (s == 0) begin : g_first
      assign rem_src = num_i[DEN_W+QUO_W-1:QUO_W];
      assign wrk_src = num_i[QUO_W-1:0];
    end else begin : g_next
      assign rem_src = rem_q[s-1];
      assign wrk_src = wrk_q[s-1];
    end

    assign trial = {rem_src, wrk_src[QUO_W-1]};
    assign ge    = trial >= {1'b0, den_i};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        wrk_q[s] <= {wrk_src[QUO_W-2:0], ge};
      end
    end

    if (s < QUO_W - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= ge ? DEN_W'(trial - {1'b0, den_i}) : trial[DEN_W-1:0];
        end
      end
    end
  end

  assign quo_o = wrk_q[QUO_W-1];

endmodule

FILE: sv/lgtp_sincos.sv
// ----------------------------------------------------------------------------
// lgtp_sincos
// Registered sine and cosine of a binary angle from a quarter-wave table.
// ----------------------------------------------------------------------------
module lgtp_sincos #(
  parameter int unsigned SINE_TABLE_DEPTH = 256
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  lgtp_pkg::bangle_t angle_i,
  output lgtp_pkg::q15_t    sin_o,
  output lgtp_pkg::q15_t    cos_o
);
  import lgtp_pkg::*;

  localparam int unsigned IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned PROD_W = 15 + IDX_W;
  localparam longint TAYLOR_DIV [6] = '{64'sd6, 64'sd20, 64'sd42, 64'sd72, 64'sd110, 64'sd156};

  typedef logic [15:0] tab_t [SINE_TABLE_DEPTH+1];

  function automatic tab_t build_tab();
    tab_t   t;
    longint a;
    longint a2;
    longint term;
    longint sum;
    longint v;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      a    = (longint'(k) * HALFPI_Q30) / SINE_TABLE_DEPTH;
      a2   = (a * a) >>> 30;
      term = a;
      sum  = a;
      for (int j = 0; j < 6; j++) begin
        term = ((term * a2) >>> 30) / TAYLOR_DIV[j];
        if (j % 2 == 0) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = (sum * 32767 + Q30_HALF) / Q30_ONE;
      if (v > 32767) begin
        v = 32767;
      end
      t[k] = v[15:0];
    end
    return t;
  endfunction

  localparam tab_t SIN_TAB = build_tab();

  function automatic q15_t sin_ba(bangle_t a);
    logic [14:0]       r;
    logic [PROD_W-1:0] p;
    logic [IDX_W-1:0]  idx;
    logic [15:0]       v;
    r = a[14] ? 15'(15'd16384 - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
    p = PROD_W'(r) * PROD_W'(SINE_TABLE_DEPTH) + PROD_W'(8192);
    idx = p[14 +: IDX_W];
    if (idx > IDX_W'(SINE_TABLE_DEPTH)) begin
      idx = IDX_W'(SINE_TABLE_DEPTH);
    end
    v = SIN_TAB[idx];
    return a[15] ? -$signed(v) : $signed(v);
  endfunction

  bangle_t angle_cos;
  assign angle_cos = angle_i + ANG_W'(16384);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_o <= sin_ba(angle_i);
      cos_o <= sin_ba(angle_cos);
    end
  end

endmodule

FILE: sv/leg_gait_trajectory_point.sv
// Throughput: one beat per cycle; the whole pipeline holds while a result is stalled.
// The depth is set by the 16-stage divide-by-point-count pipeline plus nine
// stages of input, scaling, table lookup, rotation multiply, rounding and output.
// Reset clears all valid bits and loads the configuration registers with
// n_points = 16 and zero elsewhere.
// ----------------------------------------------------------------------------
// leg_gait_trajectory_point
// Foot position of one trotting leg: swing arch, stance rotation, default end.
// ----------------------------------------------------------------------------
module leg_gait_trajectory_point #(
  parameter int unsigned SINE_TABLE_DEPTH = 256,
  parameter int unsigned POINT_BITS       = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               cmd_i,
  input  logic [9:0]         point_index_i,
  input  logic               swing_i,
  input  logic               right_side_i,
  input  logic signed [15:0] zero_x_i,
  input  logic signed [15:0] zero_y_i,
  input  logic signed [15:0] start_x_i,
  input  logic signed [15:0] start_y_i,
  input  logic signed [15:0] end_x_i,
  input  logic signed [15:0] end_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] pos_x_o,
  output logic signed [15:0] pos_y_o,
  output logic signed [15:0] pos_z_o,
  output logic [1:0]         status_o
);
  import lgtp_pkg::*;

  localparam int unsigned PW     = POINT_BITS;
  localparam int unsigned PROD_W = PW + 18;
  localparam int unsigned DVD_W  = PW + QUO_W;
  localparam int unsigned SUM_W  = 38;
  localparam int unsigned RND_W  = SUM_W - 15;
  localparam int unsigned OUT_W  = 24;

  typedef enum logic [2:0] {
    CFG_N_POINTS, CFG_BODY_HEIGHT, CFG_STEP_HEIGHT, CFG_X_LEN_LEFT,
    CFG_X_LEN_RIGHT, CFG_Y_LEN, CFG_TURN
  } cfg_reg_e;

  typedef enum logic [1:0] {MODE_SWING, MODE_STANCE, MODE_END} mode_e;
  typedef enum logic [1:0] {ST_OK, ST_STEP_HIGH, ST_RANGE} status_e;

  typedef struct packed {
    logic              cmd;
    logic [PW-1:0]     idx;
    logic              swing;
    logic              right;
    logic signed [15:0] xz, yz, sx, sy, ex, ey;
  } in_t;

  typedef struct packed {
    mode_e              mode;
    logic               oor;
    logic signed [15:0] xz, yz, sx, sy, xlen;
    logic signed [16:0] ax_end, ay_end;
    bangle_t            h_end;
  } ctx_t;

  typedef struct packed {
    ctx_t ctx;
    logic sgn_x, sgn_y, sgn_a;
  } dctx_t;

  typedef struct packed {
    mode_e              mode;
    logic               oor;
    logic signed [17:0] px_sw, py_sw;
    logic signed [15:0] xz, yz, xlen;
  } pass_t;

  // configuration
  logic [9:0]         n_points_q;
  logic [14:0]        body_height_q, step_height_q;
  logic signed [15:0] x_len_l_q, x_len_r_q, y_len_q, turn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_points_q    <= 10'd16;
      body_height_q <= '0;
      step_height_q <= '0;
      x_len_l_q     <= '0;
      x_len_r_q     <= '0;
      y_len_q       <= '0;
      turn_q        <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_N_POINTS:    n_points_q    <= cfg_data_i[9:0];
        CFG_BODY_HEIGHT: body_height_q <= cfg_data_i[14:0];
        CFG_STEP_HEIGHT: step_height_q <= cfg_data_i[14:0];
        CFG_X_LEN_LEFT:  x_len_l_q     <= cfg_data_i;
        CFG_X_LEN_RIGHT: x_len_r_q     <= cfg_data_i;
        CFG_Y_LEN:       y_len_q       <= cfg_data_i;
        CFG_TURN:        turn_q        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [15:0]   n_ext;
  logic [PW-1:0] n_raw, n_eff;
  logic          step_high;
  assign n_ext     = {6'd0, n_points_q};
  assign n_raw     = n_ext[PW-1:0];
  assign n_eff     = (n_raw == '0) ? PW'(1) : n_raw;
  assign step_high = step_height_q > body_height_q;

  // global advance: everything moves unless a finished beat waits
  logic adv;
  logic out_valid_q;
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  // stage A: input register
  logic  a_valid_q;
  in_t   a_q;
  logic [15:0] idx_ext;
  assign idx_ext = {6'd0, point_index_i};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q.cmd   <= cmd_i;
      a_q.idx   <= idx_ext[PW-1:0];
      a_q.swing <= swing_i;
      a_q.right <= right_side_i;
      a_q.xz    <= zero_x_i;
      a_q.yz    <= zero_y_i;
      a_q.sx    <= start_x_i;
      a_q.sy    <= start_y_i;
      a_q.ex    <= end_x_i;
      a_q.ey    <= end_y_i;
    end
  end

  // stage B: numerator times index
  logic               b_valid_q;
  ctx_t               b_ctx_d, b_ctx_q;
  logic signed [PROD_W-1:0] b_px_d, b_py_d, b_pa_d, b_px_q, b_py_q, b_pa_q;
  logic signed [15:0] xlen_b;
  logic signed [16:0] num_x, num_y, num_a;
  logic signed [PW:0] idx_s;

  always_comb begin
    xlen_b = a_q.right ? x_len_r_q : x_len_l_q;
    if (a_q.cmd) begin
      b_ctx_d.mode = MODE_END;
    end else if (a_q.swing) begin
      b_ctx_d.mode = MODE_SWING;
    end else begin
      b_ctx_d.mode = MODE_STANCE;
    end
    b_ctx_d.oor    = !a_q.cmd && (a_q.idx > n_eff);
    b_ctx_d.xz     = a_q.xz;
    b_ctx_d.yz     = a_q.yz;
    b_ctx_d.sx     = a_q.sx;
    b_ctx_d.sy     = a_q.sy;
    b_ctx_d.xlen   = xlen_b;
    b_ctx_d.ax_end = 17'(a_q.xz) + 17'(xlen_b);
    b_ctx_d.ay_end = 17'(a_q.yz) + 17'(y_len_q);
    b_ctx_d.h_end  = bangle_t'((17'(turn_q) + 17'(turn_q[15])) >>> 1);
    if (a_q.swing) begin
      num_x = 17'(a_q.ex) - 17'(a_q.sx);
      num_y = 17'(a_q.ey) - 17'(a_q.sy);
      num_a = 17'sd32768;
    end else begin
      num_x = 17'(xlen_b);
      num_y = 17'(y_len_q);
      num_a = 17'(turn_q);
    end
    idx_s  = $signed({1'b0, a_q.idx});
    b_px_d = num_x * idx_s;
    b_py_d = num_y * idx_s;
    b_pa_d = num_a * idx_s;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_ctx_q <= b_ctx_d;
      b_px_q  <= b_px_d;
      b_py_q  <= b_py_d;
      b_pa_q  <= b_pa_d;
    end
  end

  // stage C: sign and magnitude plus half divisor
  logic             c_valid_q;
  dctx_t            c_q;
  logic [DVD_W-1:0] c_dx_q, c_dy_q, c_da_q;
  logic [PW-1:0]    half_n;
  assign half_n = n_eff >> 1;

  function automatic logic [DVD_W-1:0] dvd_of(logic signed [PROD_W-1:0] p, logic [PW-1:0] h);
    logic [PROD_W-1:0] m;
    m = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
    return DVD_W'(m) + DVD_W'(h);
  endfunction

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_q.ctx   <= b_ctx_q;
      c_q.sgn_x <= b_px_q[PROD_W-1];
      c_q.sgn_y <= b_py_q[PROD_W-1];
      c_q.sgn_a <= b_pa_q[PROD_W-1];
      c_dx_q    <= dvd_of(b_px_q, half_n);
      c_dy_q    <= dvd_of(b_py_q, half_n);
      c_da_q    <= dvd_of(b_pa_q, half_n);
    end
  end

  // divider pipeline and its side line
  logic [QUO_W-1:0] quo_x, quo_y, quo_a;
  dctx_t            dl_q [QUO_W];
  logic             dl_valid_q [QUO_W];

  lgtp_div #(.DEN_W(PW)) u_div_x (
    .clk_i(clk_i), .en_i(adv), .den_i(n_eff), .num_i(c_dx_q), .quo_o(quo_x)
  );
  lgtp_div #(.DEN_W(PW)) u_div_y (
    .clk_i(clk_i), .en_i(adv), .den_i(n_eff), .num_i(c_dy_q), .quo_o(quo_y)
  );
  lgtp_div #(.DEN_W(PW)) u_div_a (
    .clk_i(clk_i), .en_i(adv), .den_i(n_eff), .num_i(c_da_q), .quo_o(quo_a)
  );

  for (genvar s = 0; s < QUO_W; s++) begin : g_line
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dl_q[s] <= (s == 0) ? c_q : dl_q[(s == 0) ? 0 : s-1];
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dl_valid_q[s] <= 1'b0;
      end else if (adv) begin
        dl_valid_q[s] <= (s == 0) ? c_valid_q : dl_valid_q[(s == 0) ? 0 : s-1];
      end
    end
  end

  // stage D: signed quotients, stance offsets, angle
  dctx_t              dq;
  logic signed [16:0] qx_s, qy_s, qa_s, qa_neg;
  logic               d_valid_q;
  pass_t              d_pass_q;
  logic signed [18:0] d_ax_q, d_ay_q, ax_d, ay_d;
  bangle_t            ang_d, d_ang_q;

  assign dq = dl_q[QUO_W-1];

  always_comb begin
    qx_s   = dq.sgn_x ? -$signed({1'b0, quo_x}) : $signed({1'b0, quo_x});
    qy_s   = dq.sgn_y ? -$signed({1'b0, quo_y}) : $signed({1'b0, quo_y});
    qa_s   = dq.sgn_a ? -$signed({1'b0, quo_a}) : $signed({1'b0, quo_a});
    qa_neg = -qa_s;
    case (dq.ctx.mode)
      MODE_END: begin
        ax_d  = 19'(dq.ctx.ax_end);
        ay_d  = 19'(dq.ctx.ay_end);
        ang_d = dq.ctx.h_end;
      end
      MODE_SWING: begin
        ax_d  = '0;
        ay_d  = '0;
        ang_d = quo_a;
      end
      default: begin
        ax_d  = 19'(dq.ctx.xz) + 19'(dq.ctx.sx) - 19'(qx_s);
        ay_d  = 19'(dq.ctx.yz) + 19'(dq.ctx.sy) - 19'(qy_s);
        ang_d = qa_neg[15:0];
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_pass_q.mode  <= dq.ctx.mode;
      d_pass_q.oor   <= dq.ctx.oor;
      d_pass_q.px_sw <= 18'(dq.ctx.sx) + 18'(qx_s);
      d_pass_q.py_sw <= 18'(dq.ctx.sy) + 18'(qy_s);
      d_pass_q.xz    <= dq.ctx.xz;
      d_pass_q.yz    <= dq.ctx.yz;
      d_pass_q.xlen  <= dq.ctx.xlen;
      d_ax_q         <= ax_d;
      d_ay_q         <= ay_d;
      d_ang_q        <= ang_d;
    end
  end

  // stage E: table lookup
  logic               e_valid_q;
  pass_t              e_pass_q;
  logic signed [18:0] e_ax_q, e_ay_q;
  q15_t               sin_w, cos_w;

  lgtp_sincos #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_sincos (
    .clk_i(clk_i), .en_i(adv), .angle_i(d_ang_q), .sin_o(sin_w), .cos_o(cos_w)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_pass_q <= d_pass_q;
      e_ax_q   <= d_ax_q;
      e_ay_q   <= d_ay_q;
    end
  end

  // stage F: rotation and lift products
  logic               f_valid_q;
  pass_t              f_pass_q;
  logic signed [34:0] f_m0_q, f_m1_q, f_m2_q, f_m3_q;
  logic signed [32:0] f_mz_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_pass_q <= e_pass_q;
      f_m0_q   <= e_ax_q * cos_w;
      f_m1_q   <= e_ay_q * sin_w;
      f_m2_q   <= e_ax_q * sin_w;
      f_m3_q   <= e_ay_q * cos_w;
      f_mz_q   <= $signed({1'b0, step_height_q}) * sin_w;
    end
  end

  // stage G: sums
  logic                    g_valid_q;
  pass_t                   g_pass_q;
  logic signed [SUM_W-1:0] g_sx_q, g_sy_q, g_sz_q, xterm, yterm;

  always_comb begin
    if (f_pass_q.mode == MODE_END) begin
      xterm = -(SUM_W'(f_pass_q.xlen) <<< 14);
      yterm = -(SUM_W'(y_len_q) <<< 14);
    end else begin
      xterm = '0;
      yterm = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      g_pass_q <= f_pass_q;
      g_sx_q   <= SUM_W'(f_m0_q) - SUM_W'(f_m1_q) + xterm;
      g_sy_q   <= SUM_W'(f_m2_q) + SUM_W'(f_m3_q) + yterm;
      g_sz_q   <= SUM_W'(f_mz_q);
    end
  end

  // stage H: round to nearest, ties away from zero, after >> 15
  function automatic logic signed [RND_W-1:0] rnd15(logic signed [SUM_W-1:0] v);
    logic [SUM_W-1:0] m;
    logic [SUM_W-1:0] r;
    m = v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
    r = (m + SUM_W'(16384)) >> 15;
    return v[SUM_W-1] ? -$signed(r[RND_W-1:0]) : $signed(r[RND_W-1:0]);
  endfunction

  logic                    h_valid_q;
  pass_t                   h_pass_q;
  logic signed [RND_W-1:0] h_rx_q, h_ry_q, h_rz_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      h_pass_q <= g_pass_q;
      h_rx_q   <= rnd15(g_sx_q);
      h_ry_q   <= rnd15(g_sy_q);
      h_rz_q   <= rnd15(g_sz_q);
    end
  end

  // output stage
  function automatic logic signed [15:0] sat16(logic signed [OUT_W-1:0] v);
    if (v > OUT_W'(32767)) begin
      return 16'sh7fff;
    end else if (v < -OUT_W'(32768)) begin
      return -16'sh8000;
    end
    return v[15:0];
  endfunction

  logic signed [15:0] pos_x_d, pos_y_d, pos_z_d;
  logic [1:0]         status_d;
  logic signed [OUT_W-1:0] bh_w;
  assign bh_w = OUT_W'($signed({1'b0, body_height_q}));

  always_comb begin
    status_d = step_high ? ST_STEP_HIGH : ST_OK;
    if (h_pass_q.oor) begin
      pos_x_d  = '0;
      pos_y_d  = '0;
      pos_z_d  = '0;
      status_d = ST_RANGE;
    end else if (h_pass_q.mode == MODE_SWING) begin
      pos_x_d = sat16(OUT_W'(h_pass_q.px_sw));
      pos_y_d = sat16(OUT_W'(h_pass_q.py_sw));
      pos_z_d = sat16(bh_w - OUT_W'(h_rz_q));
    end else begin
      pos_x_d = sat16(OUT_W'(h_rx_q) - OUT_W'(h_pass_q.xz));
      pos_y_d = sat16(OUT_W'(h_ry_q) - OUT_W'(h_pass_q.yz));
      pos_z_d = sat16(bh_w);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pos_x_o  <= pos_x_d;
      pos_y_o  <= pos_y_d;
      pos_z_o  <= pos_z_d;
      status_o <= status_d;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      d_valid_q   <= 1'b0;
      e_valid_q   <= 1'b0;
      f_valid_q   <= 1'b0;
      g_valid_q   <= 1'b0;
      h_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q   <= in_valid_i;
      b_valid_q   <= a_valid_q;
      c_valid_q   <= b_valid_q;
      d_valid_q   <= dl_valid_q[QUO_W-1];
      e_valid_q   <= d_valid_q;
      f_valid_q   <= e_valid_q;
      g_valid_q   <= f_valid_q;
      h_valid_q   <= g_valid_q;
      out_valid_q <= h_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
